// File: sv/battery_pack_supervisor_fsm_macros.svh
// Assertion macros for the battery pack supervisor.
`ifndef BATTERY_PACK_SUPERVISOR_FSM_MACROS_SVH
`define BATTERY_PACK_SUPERVISOR_FSM_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define BPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bps_pkg.sv
// Types, constants and transition function shared by the battery pack supervisor.
package bps_pkg;

  localparam int VOLT_W     = 13;
  localparam int TEMP_W     = 12;
  localparam int LEN_W      = 6;
  localparam int EXT_W      = 14;
  localparam int WINDOW_MAX = 63;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int CFG_IDX_W  = 3;

  localparam logic [VOLT_W-1:0]        VOLT_LOW_RST  = VOLT_W'(2500);
  localparam logic [VOLT_W-1:0]        VOLT_HIGH_RST = VOLT_W'(4200);
  localparam logic signed [TEMP_W-1:0] DRV_LOW_RST   = -TEMP_W'(200);
  localparam logic signed [TEMP_W-1:0] DRV_HIGH_RST  = TEMP_W'(600);
  localparam logic signed [TEMP_W-1:0] CHG_LOW_RST   = TEMP_W'(0);
  localparam logic signed [TEMP_W-1:0] CHG_HIGH_RST  = TEMP_W'(450);
  localparam logic [LEN_W-1:0]         LEN_RST       = LEN_W'(10);

  // Window idle values: min starts at top of range, max at bottom.
  localparam logic [VOLT_W-1:0]        VOLT_MIN_IDLE = '1;
  localparam logic [VOLT_W-1:0]        VOLT_MAX_IDLE = '0;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN_IDLE = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_IDLE = {1'b1, {(TEMP_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRV_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRV_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 3'd6;

  typedef enum logic [2:0] {
    MODE_OFF         = 3'd0,
    MODE_PRECHARGE   = 3'd1,
    MODE_ENERGIZED   = 3'd2,
    MODE_READY       = 3'd3,
    MODE_FAULT       = 3'd4,
    MODE_CHARGING    = 3'd5,
    MODE_CHG_FAULT   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_VOLT  = 2'd1,
    KIND_TEMP  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    EV_START         = 4'd0,
    EV_CHARGER       = 4'd1,
    EV_PRECHARGE_OK  = 4'd2,
    EV_CHARGE_DONE   = 4'd3,
    EV_READY_REQ     = 4'd4,
    EV_EXIT_READY    = 4'd5,
    EV_SHUTDOWN      = 4'd6,
    EV_VOLT_FAULT    = 4'd7,
    EV_TEMP_FAULT    = 4'd8,
    EV_FUSE_FAULT    = 4'd9,
    EV_MISSING_READ  = 4'd10,
    EV_INTERNAL      = 4'd11,
    EV_MANUAL_RESET  = 4'd12,
    EV_NONE          = 4'd13
  } event_t;

  function automatic logic is_monitoring(mode_t m);
    return (m == MODE_PRECHARGE) || (m == MODE_ENERGIZED) ||
           (m == MODE_READY) || (m == MODE_CHARGING);
  endfunction

  function automatic logic is_fault_event(logic [3:0] ev);
    return ev inside {EV_VOLT_FAULT, EV_TEMP_FAULT, EV_FUSE_FAULT,
                      EV_MISSING_READ, EV_INTERNAL};
  endfunction

  // Mode transition table. Codes past EV_NONE change nothing.
  function automatic mode_t next_mode(mode_t m, logic [3:0] ev);
    mode_t nm;
    nm = m;
    unique case (m)
      MODE_OFF: begin
        if (ev == EV_START) nm = MODE_PRECHARGE;
        else if (ev == EV_CHARGER) nm = MODE_CHARGING;
      end
      MODE_PRECHARGE: begin
        if (ev == EV_PRECHARGE_OK) nm = MODE_ENERGIZED;
        else if (ev == EV_SHUTDOWN) nm = MODE_OFF;
        else if (is_fault_event(ev)) nm = MODE_FAULT;
      end
      MODE_ENERGIZED: begin
        if (ev == EV_READY_REQ) nm = MODE_READY;
        else if (ev == EV_SHUTDOWN) nm = MODE_OFF;
        else if (is_fault_event(ev)) nm = MODE_FAULT;
      end
      MODE_READY: begin
        if (ev == EV_SHUTDOWN) nm = MODE_OFF;
        else if (is_fault_event(ev)) nm = MODE_FAULT;
        else if (ev == EV_EXIT_READY) nm = MODE_ENERGIZED;
      end
      MODE_CHARGING: begin
        if (ev == EV_SHUTDOWN || ev == EV_CHARGE_DONE) nm = MODE_OFF;
        else if (is_fault_event(ev)) nm = MODE_CHG_FAULT;
      end
      MODE_FAULT, MODE_CHG_FAULT: begin
        if (ev == EV_MANUAL_RESET) nm = MODE_OFF;
      end
      default: nm = m;
    endcase
    return nm;
  endfunction

endpackage

// File: sv/bps_channels.sv
// Handshake channel interfaces: input item, result item and config write.
interface bps_item_if import bps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [3:0]               event_code;
  logic [VOLT_W-1:0]        cell_millivolts;
  logic signed [TEMP_W-1:0] cell_decidegrees;

  modport source (output valid, kind, event_code, cell_millivolts, cell_decidegrees,
                  input ready);
  modport sink   (input valid, kind, event_code, cell_millivolts, cell_decidegrees,
                  output ready);
endinterface

interface bps_result_if import bps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              mode;
  logic                    monitoring;
  logic                    reading_dropped;
  logic                    window_closed;
  logic                    window_fault;
  logic signed [EXT_W-1:0] window_lowest;
  logic signed [EXT_W-1:0] window_highest;

  modport source (output valid, mode, monitoring, reading_dropped, window_closed,
                  window_fault, window_lowest, window_highest, input ready);
  modport sink   (input valid, mode, monitoring, reading_dropped, window_closed,
                  window_fault, window_lowest, window_highest, output ready);
endinterface

interface bps_cfg_if import bps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VOLT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/battery_pack_supervisor_fsm.sv
// Battery pack supervisor: mode state machine with voltage and temperature windows.
//
//   channel  role  carries
//   -------  ----  -------------------------------------------------------------
//   item     sink  kind, event_code, cell_millivolts, cell_decidegrees
//   result   src   mode, monitoring, reading_dropped, window_closed/fault, lo/hi
//   cfg      sink  index (register number), data (write value)
//
// One item per cycle; its result appears in the result register in the cycle
// after acceptance. The mode and window registers are updated at acceptance, so
// the next item sees them at once. item.ready drops only while a result is
// held unread (result.valid high, result.ready low). rst is synchronous; no
// clearing pass. cfg is always ready and takes effect on the next item.
`include "battery_pack_supervisor_fsm_macros.svh"

module battery_pack_supervisor_fsm import bps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bps_item_if.sink   item,
  bps_result_if.source result,
  bps_cfg_if.sink    cfg
);

  // Configuration registers
  logic [VOLT_W-1:0]        volt_low;
  logic [VOLT_W-1:0]        volt_high;
  logic signed [TEMP_W-1:0] drv_low;
  logic signed [TEMP_W-1:0] drv_high;
  logic signed [TEMP_W-1:0] chg_low;
  logic signed [TEMP_W-1:0] chg_high;
  logic [LEN_W-1:0]         win_len;

  // Supervisor state
  mode_t                    mode;
  mode_t                    mode_next;
  logic [VOLT_W-1:0]        volt_min, volt_min_next;
  logic [VOLT_W-1:0]        volt_max, volt_max_next;
  logic [CNT_W-1:0]         volt_cnt, volt_cnt_next;
  logic signed [TEMP_W-1:0] temp_min, temp_min_next;
  logic signed [TEMP_W-1:0] temp_max, temp_max_next;
  logic [CNT_W-1:0]         temp_cnt, temp_cnt_next;

  // Result register
  logic                    res_valid;
  mode_t                   res_mode, res_mode_next;
  logic                    res_mon, res_mon_next;
  logic                    res_drop, res_drop_next;
  logic                    res_closed, res_closed_next;
  logic                    res_fault, res_fault_next;
  logic signed [EXT_W-1:0] res_lo, res_lo_next;
  logic signed [EXT_W-1:0] res_hi, res_hi_next;

  logic in_ready;
  logic accept;

  // Datapath terms
  kind_t                    kind;
  logic                     mon;
  logic [CNT_W-1:0]         eff_len;
  logic [VOLT_W-1:0]        v_min_upd, v_max_upd;
  logic [CNT_W-1:0]         v_cnt_inc;
  logic                     v_close, v_breach;
  logic signed [TEMP_W-1:0] t_min_upd, t_max_upd;
  logic signed [TEMP_W-1:0] t_lim_lo, t_lim_hi;
  logic [CNT_W-1:0]         t_cnt_inc;
  logic                     t_close, t_breach;
  logic                     volt_take, temp_take;

  // Output register frees the input side whenever it is empty or being drained.
  assign in_ready     = !res_valid || result.ready;
  assign item.ready   = in_ready;
  assign accept       = item.valid && in_ready;
  assign cfg.ready    = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_low  <= VOLT_LOW_RST;
      volt_high <= VOLT_HIGH_RST;
      drv_low   <= DRV_LOW_RST;
      drv_high  <= DRV_HIGH_RST;
      chg_low   <= CHG_LOW_RST;
      chg_high  <= CHG_HIGH_RST;
      win_len   <= LEN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_VOLT_LOW:  volt_low  <= cfg.data;
        CFG_VOLT_HIGH: volt_high <= cfg.data;
        CFG_DRV_LOW:   drv_low   <= cfg.data[TEMP_W-1:0];
        CFG_DRV_HIGH:  drv_high  <= cfg.data[TEMP_W-1:0];
        CFG_CHG_LOW:   chg_low   <= cfg.data[TEMP_W-1:0];
        CFG_CHG_HIGH:  chg_high  <= cfg.data[TEMP_W-1:0];
        CFG_WIN_LEN:   win_len   <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Window datapath: min/max update, count, close and limit check.
  always_comb begin
    kind = kind_t'(item.kind);
    mon  = is_monitoring(mode);

    // Zero length acts as one; lengths past WINDOW_MAX saturate.
    if (win_len == '0)
      eff_len = CNT_W'(1);
    else if (int'(win_len) > WINDOW_MAX)
      eff_len = CNT_W'(WINDOW_MAX);
    else
      eff_len = CNT_W'(win_len);

    v_min_upd = (item.cell_millivolts < volt_min) ? item.cell_millivolts : volt_min;
    v_max_upd = (item.cell_millivolts > volt_max) ? item.cell_millivolts : volt_max;
    v_cnt_inc = volt_cnt + CNT_W'(1);
    v_close   = v_cnt_inc >= eff_len;
    v_breach  = (v_min_upd < volt_low) || (v_max_upd > volt_high);

    t_min_upd = (item.cell_decidegrees < temp_min) ? item.cell_decidegrees : temp_min;
    t_max_upd = (item.cell_decidegrees > temp_max) ? item.cell_decidegrees : temp_max;
    t_cnt_inc = temp_cnt + CNT_W'(1);
    t_close   = t_cnt_inc >= eff_len;
    // Charging has its own temperature limits.
    t_lim_lo  = (mode == MODE_CHARGING) ? chg_low  : drv_low;
    t_lim_hi  = (mode == MODE_CHARGING) ? chg_high : drv_high;
    t_breach  = (t_min_upd < t_lim_lo) || (t_max_upd > t_lim_hi);

    volt_take = (kind == KIND_VOLT) && mon;
    temp_take = (kind == KIND_TEMP) && mon;
  end

  // ---------------------------------------------------------------------------
  // Next state: mode and windows.
  always_comb begin
    mode_next     = mode;
    volt_min_next = volt_min;
    volt_max_next = volt_max;
    volt_cnt_next = volt_cnt;
    temp_min_next = temp_min;
    temp_max_next = temp_max;
    temp_cnt_next = temp_cnt;

    case (kind)
      KIND_EVENT: mode_next = next_mode(mode, item.event_code);
      KIND_VOLT: begin
        if (volt_take) begin
          if (v_close) begin
            if (v_breach) mode_next = next_mode(mode, EV_VOLT_FAULT);
            volt_min_next = VOLT_MIN_IDLE;
            volt_max_next = VOLT_MAX_IDLE;
            volt_cnt_next = '0;
          end else begin
            volt_min_next = v_min_upd;
            volt_max_next = v_max_upd;
            volt_cnt_next = v_cnt_inc;
          end
        end
      end
      KIND_TEMP: begin
        if (temp_take) begin
          if (t_close) begin
            if (t_breach) mode_next = next_mode(mode, EV_TEMP_FAULT);
            temp_min_next = TEMP_MIN_IDLE;
            temp_max_next = TEMP_MAX_IDLE;
            temp_cnt_next = '0;
          end else begin
            temp_min_next = t_min_upd;
            temp_max_next = t_max_upd;
            temp_cnt_next = t_cnt_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result fields for the item being accepted.
  always_comb begin
    res_mode_next   = mode_next;
    res_mon_next    = is_monitoring(mode_next);
    res_drop_next   = ((kind == KIND_VOLT) || (kind == KIND_TEMP)) && !mon;
    res_closed_next = 1'b0;
    res_fault_next  = 1'b0;
    res_lo_next     = '0;
    res_hi_next     = '0;
    if (volt_take && v_close) begin
      res_closed_next = 1'b1;
      res_fault_next  = v_breach;
      res_lo_next     = EXT_W'(v_min_upd);
      res_hi_next     = EXT_W'(v_max_upd);
    end else if (temp_take && t_close) begin
      res_closed_next = 1'b1;
      res_fault_next  = t_breach;
      res_lo_next     = EXT_W'(t_min_upd);
      res_hi_next     = EXT_W'(t_max_upd);
    end
  end

  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_OFF;
      volt_min <= VOLT_MIN_IDLE;
      volt_max <= VOLT_MAX_IDLE;
      volt_cnt <= '0;
      temp_min <= TEMP_MIN_IDLE;
      temp_max <= TEMP_MAX_IDLE;
      temp_cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        mode     <= mode_next;
        volt_min <= volt_min_next;
        volt_max <= volt_max_next;
        volt_cnt <= volt_cnt_next;
        temp_min <= temp_min_next;
        temp_max <= temp_max_next;
        temp_cnt <= temp_cnt_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded only on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_mode   <= res_mode_next;
      res_mon    <= res_mon_next;
      res_drop   <= res_drop_next;
      res_closed <= res_closed_next;
      res_fault  <= res_fault_next;
      res_lo     <= res_lo_next;
      res_hi     <= res_hi_next;
    end
  end

  assign result.valid           = res_valid;
  assign result.mode            = res_mode;
  assign result.monitoring      = res_mon;
  assign result.reading_dropped = res_drop;
  assign result.window_closed   = res_closed;
  assign result.window_fault    = res_fault;
  assign result.window_lowest   = res_lo;
  assign result.window_highest  = res_hi;

  // ---------------------------------------------------------------------------
  `BPS_ASSERT_NOW(a_fault_needs_close, clk, rst,
    result.valid && result.window_fault, result.window_closed,
    "window fault without a closed window")
  `BPS_ASSERT_NOW(a_drop_no_close, clk, rst,
    result.valid && result.reading_dropped, !result.window_closed,
    "dropped reading closed a window")
  `BPS_ASSERT_NOW(a_fault_mode, clk, rst,
    result.valid && result.window_fault,
    result.mode == MODE_FAULT || result.mode == MODE_CHG_FAULT,
    "window fault left mode outside a fault state")
  `BPS_ASSERT_NOW(a_stall_blocks_input, clk, rst,
    result.valid && !result.ready, !item.ready,
    "item taken while result held")
  `BPS_ASSERT_NOW(a_count_bound, clk, rst,
    1'b1, int'(volt_cnt) < WINDOW_MAX && int'(temp_cnt) < WINDOW_MAX,
    "window count reached its maximum without closing")

endmodule

// File: sim/battery_pack_supervisor_fsm_test.sv
// Self-checking testbench for the battery pack supervisor: random and directed items, scored.
module battery_pack_supervisor_fsm_test import bps_pkg::*; ();

  // Codes the package enums do not name: the unused kind and the two unknown events.
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam logic [3:0] EV_SPARE_LO = 4'd14;
  localparam logic [3:0] EV_SPARE_HI = 4'd15;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 115;   // random items per phase, sessions may overshoot
  localparam int HOLD_CYCLES = 300;   // long result back-pressure in the hold phase
  localparam int HOLD_PHASE  = 4;
  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all before giving up
  localparam int TAIL_CYCLES = 4;     // result register is one deep

  typedef struct {
    logic [1:0]               kind;
    logic [3:0]               event_code;
    logic [VOLT_W-1:0]        millivolts;
    logic signed [TEMP_W-1:0] decidegrees;
  } cell_item_t;

  typedef struct {
    mode_t                   mode;
    logic                    monitoring;
    logic                    dropped;
    logic                    closed;
    logic                    breach;
    logic signed [EXT_W-1:0] lowest;
    logic signed [EXT_W-1:0] highest;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bps_item_if   item_ch();
  bps_result_if result_ch();
  bps_cfg_if    cfg_ch();

  battery_pack_supervisor_fsm dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #4 clk = ~clk;

  // Stimulus queue, filled by the sequencer, drained by the item driver.
  cell_item_t pending_items[$];
  report_t    expected_reports[$];
  int         n_pushed   = 0;
  int         n_accepted = 0;
  int         n_results  = 0;
  int         errors     = 0;
  int         quiet_cycles = 0;
  logic       item_fire  = 1'b0;

  // Pacing knobs, percent of cycles spent idle (sender) or stalled (receiver).
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_toggle    = 1'b0;  // flipped by the sequencer to request a long stall
  bit hold_seen      = 1'b0;
  int hold_left      = 0;

  // Shadow of the supervisor: configuration and state.
  logic [VOLT_W-1:0]        lim_volt_low, lim_volt_high;
  logic signed [TEMP_W-1:0] lim_drv_low, lim_drv_high, lim_chg_low, lim_chg_high;
  logic [LEN_W-1:0]         win_len;
  mode_t                    mode_now;
  logic [VOLT_W-1:0]        volt_lo_seen, volt_hi_seen;
  logic signed [TEMP_W-1:0] temp_lo_seen, temp_hi_seen;
  int                       volt_taken, temp_taken;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic mode_watches_cells(mode_t m);
    return m == MODE_PRECHARGE || m == MODE_ENERGIZED || m == MODE_READY ||
           m == MODE_CHARGING;
  endfunction

  // Event table. Fault events are the contiguous run from volt fault to internal.
  function automatic mode_t advance_mode(mode_t m, logic [3:0] ev);
    logic is_fault;
    is_fault = ev >= EV_VOLT_FAULT && ev <= EV_INTERNAL;
    case (m)
      MODE_OFF: begin
        if (ev == EV_START) return MODE_PRECHARGE;
        if (ev == EV_CHARGER) return MODE_CHARGING;
      end
      MODE_PRECHARGE: begin
        if (ev == EV_PRECHARGE_OK) return MODE_ENERGIZED;
        if (ev == EV_SHUTDOWN) return MODE_OFF;
        if (is_fault) return MODE_FAULT;
      end
      MODE_ENERGIZED: begin
        if (ev == EV_READY_REQ) return MODE_READY;
        if (ev == EV_SHUTDOWN) return MODE_OFF;
        if (is_fault) return MODE_FAULT;
      end
      MODE_READY: begin
        if (ev == EV_SHUTDOWN) return MODE_OFF;
        if (is_fault) return MODE_FAULT;
        if (ev == EV_EXIT_READY) return MODE_ENERGIZED;
      end
      MODE_CHARGING: begin
        if (ev == EV_SHUTDOWN || ev == EV_CHARGE_DONE) return MODE_OFF;
        if (is_fault) return MODE_CHG_FAULT;
      end
      MODE_FAULT, MODE_CHG_FAULT: begin
        if (ev == EV_MANUAL_RESET) return MODE_OFF;
      end
      default: ;
    endcase
    return m;
  endfunction

  // Zero length behaves as one; the 6-bit register cannot exceed WINDOW_MAX.
  function automatic int window_span();
    return (win_len == '0) ? 1 : int'(win_len);
  endfunction

  function automatic void clear_volt_window();
    volt_lo_seen = VOLT_MIN_IDLE;
    volt_hi_seen = VOLT_MAX_IDLE;
    volt_taken   = 0;
  endfunction

  function automatic void clear_temp_window();
    temp_lo_seen = TEMP_MIN_IDLE;
    temp_hi_seen = TEMP_MAX_IDLE;
    temp_taken   = 0;
  endfunction

  // One accepted item in, one report out; updates the shadow state.
  function automatic report_t supervise_item(cell_item_t it);
    report_t                  r;
    logic signed [TEMP_W-1:0] t_low, t_high;
    r.dropped = 1'b0;
    r.closed  = 1'b0;
    r.breach  = 1'b0;
    r.lowest  = '0;
    r.highest = '0;
    case (it.kind)
      KIND_EVENT: mode_now = advance_mode(mode_now, it.event_code);
      KIND_VOLT, KIND_TEMP: begin
        if (!mode_watches_cells(mode_now)) begin
          r.dropped = 1'b1;  // window untouched
        end else if (it.kind == KIND_VOLT) begin
          if (it.millivolts < volt_lo_seen) volt_lo_seen = it.millivolts;
          if (it.millivolts > volt_hi_seen) volt_hi_seen = it.millivolts;
          volt_taken++;
          // >= so that a length lowered mid-window closes on the next reading
          if (volt_taken >= window_span()) begin
            r.closed  = 1'b1;
            r.lowest  = {1'b0, volt_lo_seen};
            r.highest = {1'b0, volt_hi_seen};
            r.breach  = volt_lo_seen < lim_volt_low || volt_hi_seen > lim_volt_high;
            if (r.breach) mode_now = advance_mode(mode_now, EV_VOLT_FAULT);
            clear_volt_window();
          end
        end else begin
          if (it.decidegrees < temp_lo_seen) temp_lo_seen = it.decidegrees;
          if (it.decidegrees > temp_hi_seen) temp_hi_seen = it.decidegrees;
          temp_taken++;
          if (temp_taken >= window_span()) begin
            r.closed  = 1'b1;
            r.lowest  = EXT_W'(temp_lo_seen);   // sign-extends to 14 bits
            r.highest = EXT_W'(temp_hi_seen);
            // limits picked from the mode before any fault is applied
            if (mode_now == MODE_CHARGING) begin
              t_low  = lim_chg_low;
              t_high = lim_chg_high;
            end else begin
              t_low  = lim_drv_low;
              t_high = lim_drv_high;
            end
            r.breach = temp_lo_seen < t_low || temp_hi_seen > t_high;
            if (r.breach) mode_now = advance_mode(mode_now, EV_TEMP_FAULT);
            clear_temp_window();
          end
        end
      end
      default: ;  // spare kind: nothing moves
    endcase
    r.mode       = mode_now;
    r.monitoring = mode_watches_cells(mode_now);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard, prediction and watchdog, all at the rising edge in one process
  // so that a result and an item taken at the same edge are handled in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : score
    report_t    want;
    cell_item_t seen;
    logic       moved;
    if (rst) begin
      lim_volt_low  = VOLT_LOW_RST;
      lim_volt_high = VOLT_HIGH_RST;
      lim_drv_low   = DRV_LOW_RST;
      lim_drv_high  = DRV_HIGH_RST;
      lim_chg_low   = CHG_LOW_RST;
      lim_chg_high  = CHG_HIGH_RST;
      win_len       = LEN_RST;
      mode_now      = MODE_OFF;
      clear_volt_window();
      clear_temp_window();
      quiet_cycles = 0;
      item_fire   <= 1'b0;
    end else begin
      moved = 1'b0;

      // Check the result first: it belongs to an item taken on an earlier edge.
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        n_results++;
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected (mode=%0d)",
                               n_results, result_ch.mode));
        end else begin
          want = expected_reports.pop_front();
          if (result_ch.mode !== want.mode ||
              result_ch.monitoring !== want.monitoring ||
              result_ch.reading_dropped !== want.dropped ||
              result_ch.window_closed !== want.closed ||
              result_ch.window_fault !== want.breach ||
              result_ch.window_lowest !== want.lowest ||
              result_ch.window_highest !== want.highest)
            flag_error($sformatf({"result %0d mismatch: want mode=%0d mon=%0b drop=%0b ",
                                  "close=%0b flt=%0b lo=%0d hi=%0d, got mode=%0d mon=%0b ",
                                  "drop=%0b close=%0b flt=%0b lo=%0d hi=%0d"},
                                 n_results, want.mode, want.monitoring, want.dropped,
                                 want.closed, want.breach, want.lowest, want.highest,
                                 result_ch.mode, result_ch.monitoring,
                                 result_ch.reading_dropped, result_ch.window_closed,
                                 result_ch.window_fault, result_ch.window_lowest,
                                 result_ch.window_highest));
        end
      end

      if (item_ch.valid && item_ch.ready) begin
        moved = 1'b1;
        seen.kind        = item_ch.kind;
        seen.event_code  = item_ch.event_code;
        seen.millivolts  = item_ch.cell_millivolts;
        seen.decidegrees = item_ch.cell_decidegrees;
        expected_reports.push_back(supervise_item(seen));
        n_accepted++;
      end

      // Register writes only happen while idle; they apply to the next item.
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        case (cfg_ch.index)
          CFG_VOLT_LOW:  lim_volt_low  = cfg_ch.data;
          CFG_VOLT_HIGH: lim_volt_high = cfg_ch.data;
          CFG_DRV_LOW:   lim_drv_low   = cfg_ch.data[TEMP_W-1:0];
          CFG_DRV_HIGH:  lim_drv_high  = cfg_ch.data[TEMP_W-1:0];
          CFG_CHG_LOW:   lim_chg_low   = cfg_ch.data[TEMP_W-1:0];
          CFG_CHG_HIGH:  lim_chg_high  = cfg_ch.data[TEMP_W-1:0];
          CFG_WIN_LEN:   win_len       = cfg_ch.data[LEN_W-1:0];
          default: ;
        endcase
      end

      item_fire <= item_ch.valid && item_ch.ready;

      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item driver: presents the next queued item at the falling edge, holding it
  // until taken; idles at random per send_idle_pct.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_items
    cell_item_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_fire) begin
      if (pending_items.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        item_ch.valid            <= 1'b1;
        item_ch.kind             <= nxt.kind;
        item_ch.event_code       <= nxt.event_code;
        item_ch.cell_millivolts  <= nxt.millivolts;
        item_ch.cell_decidegrees <= nxt.decidegrees;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk) begin : pace_results
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_seen != hold_toggle) begin
      hold_seen       <= hold_toggle;
      hold_left       <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= int'($urandom_range(99)) >= recv_stall_pct;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  function automatic int rand_between(int a, int b);
    int lo_v, hi_v;
    lo_v = (a < b) ? a : b;
    hi_v = (a < b) ? b : a;
    return lo_v + int'($urandom_range(hi_v - lo_v));
  endfunction

  task automatic queue_item(input logic [1:0] kind, input logic [3:0] ev,
                            input logic [VOLT_W-1:0] mv,
                            input logic signed [TEMP_W-1:0] dd);
    cell_item_t it;
    it.kind        = kind;
    it.event_code  = ev;
    it.millivolts  = mv;
    it.decidegrees = dd;
    pending_items.push_back(it);
    n_pushed++;
  endtask

  // Unused fields carry noise; the block has to ignore them.
  task automatic queue_event(input logic [3:0] ev);
    queue_item(KIND_EVENT, ev, VOLT_W'($urandom), TEMP_W'($urandom));
  endtask

  // Mixed voltage and temperature readings, mostly inside the limits, some on
  // the edges, some anywhere in the field.
  task automatic queue_readings(input int n);
    int pick, v, lo_t, hi_t;
    repeat (n) begin
      pick = $urandom_range(99);
      if ($urandom_range(1)) begin
        if (pick < 70)
          v = rand_between(int'(lim_volt_low), int'(lim_volt_high));
        else if (pick < 85)
          v = $urandom_range(1) ? int'(lim_volt_low) - int'($urandom_range(1))
                                : int'(lim_volt_high) + int'($urandom_range(1));
        else
          v = $urandom_range(8191);
        queue_item(KIND_VOLT, 4'($urandom), VOLT_W'(v), TEMP_W'($urandom));
      end else begin
        // the generator cannot be sure of the mode, so either limit set may apply
        if ($urandom_range(1)) begin
          lo_t = int'(lim_chg_low);
          hi_t = int'(lim_chg_high);
        end else begin
          lo_t = int'(lim_drv_low);
          hi_t = int'(lim_drv_high);
        end
        if (pick < 70)
          v = rand_between(lo_t, hi_t);
        else if (pick < 85)
          v = $urandom_range(1) ? lo_t - int'($urandom_range(1)) : hi_t + int'($urandom_range(1));
        else if (pick < 95)
          v = rand_between(-1000, 2000);
        else
          v = rand_between(-2048, 2047);
        queue_item(KIND_TEMP, 4'($urandom), VOLT_W'($urandom), TEMP_W'(v));
      end
    end
  endtask

  function automatic int burst_len();
    return int'($urandom_range(window_span() + 3, 1));
  endfunction

  // One power session: a drive cycle or a charge cycle with readings between
  // the steps, sometimes a fault, always brought back to off at the end.
  task automatic queue_session();
    int fault_ev;
    fault_ev = int'(EV_VOLT_FAULT) + int'($urandom_range(4));
    if ($urandom_range(99) < 30) begin
      queue_event(EV_CHARGER);
      queue_readings(burst_len());
      case ($urandom_range(2))
        0: queue_event(EV_CHARGE_DONE);
        1: queue_event(EV_SHUTDOWN);
        default: begin
          queue_event(4'(fault_ev));
          queue_readings(2);
        end
      endcase
    end else begin
      queue_event(EV_START);
      queue_readings(burst_len());
      queue_event(EV_PRECHARGE_OK);
      queue_readings(burst_len());
      queue_event(EV_READY_REQ);
      queue_readings(burst_len());
      if ($urandom_range(1)) begin
        queue_event(EV_EXIT_READY);
        queue_readings(burst_len());
        queue_event(EV_READY_REQ);
      end
      if ($urandom_range(2) == 0) begin
        queue_event(4'(fault_ev));
        queue_readings(2);
      end
    end
    if ($urandom_range(3) == 0) queue_event(4'($urandom_range(15)));
    queue_event(EV_SHUTDOWN);
    queue_event(EV_MANUAL_RESET);
  endtask

  // Holds valid high across back-to-back writes; caller lowers it afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= VOLT_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_limits(input int v_low, input int v_high, input int d_low,
                                input int d_high, input int c_low, input int c_high,
                                input int length);
    write_reg(CFG_VOLT_LOW, v_low);
    write_reg(CFG_VOLT_HIGH, v_high);
    write_reg(CFG_DRV_LOW, d_low);
    write_reg(CFG_DRV_HIGH, d_high);
    write_reg(CFG_CHG_LOW, c_low);
    write_reg(CFG_CHG_HIGH, c_high);
    write_reg(CFG_WIN_LEN, length);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Every item taken and every result scored.
  task automatic drain_results();
    while (n_accepted < n_pushed || expected_reports.size() != 0) @(negedge clk);
  endtask

  initial begin : sequencer
    int phase;
    int budget;
    item_ch.valid            = 1'b0;
    item_ch.kind             = KIND_EVENT;
    item_ch.event_code       = EV_NONE;
    item_ch.cell_millivolts  = '0;
    item_ch.cell_decidegrees = '0;
    result_ch.ready          = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = CFG_VOLT_LOW;
    cfg_ch.data              = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset limits, no idling.
    queue_item(KIND_TEMP, 4'($urandom), VOLT_W'($urandom), -TEMP_W'(1000)); // dropped in off
    queue_item(KIND_VOLT, 4'($urandom), VOLT_W'(8191), TEMP_W'($urandom));  // dropped in off
    queue_item(KIND_SPARE, 4'($urandom), VOLT_W'($urandom), TEMP_W'($urandom));
    queue_event(EV_SPARE_LO);     // unknown codes act as none
    queue_event(EV_SPARE_HI);
    queue_event(EV_CHARGER);
    queue_event(EV_CHARGE_DONE);
    queue_event(EV_START);
    queue_event(EV_PRECHARGE_OK);
    queue_event(EV_READY_REQ);
    queue_event(EV_EXIT_READY);
    queue_event(EV_FUSE_FAULT);
    queue_event(EV_START);        // ignored while in fault
    queue_event(EV_MANUAL_RESET);
    queue_event(EV_CHARGER);
    queue_event(EV_INTERNAL);     // charge fault
    queue_event(EV_MANUAL_RESET);
    queue_event(EV_START);
    queue_event(EV_NONE);
    // Four voltage readings left open in a length-10 window; phase 0 drops the
    // length to 3, so its first voltage reading closes an overfull window.
    queue_item(KIND_VOLT, 4'($urandom), VOLT_W'(0), TEMP_W'($urandom));
    queue_item(KIND_TEMP, 4'($urandom), VOLT_W'($urandom), TEMP_W'(2000));
    queue_item(KIND_VOLT, 4'($urandom), VOLT_W'(4200), TEMP_W'($urandom));
    queue_item(KIND_TEMP, 4'($urandom), VOLT_W'($urandom), -TEMP_W'(1000));
    queue_item(KIND_VOLT, 4'($urandom), VOLT_W'(2500), TEMP_W'($urandom));
    queue_item(KIND_VOLT, 4'($urandom), VOLT_W'(8191), TEMP_W'($urandom));
    drain_results();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_limits(2500, 4200, -200, 600, 0, 450, 3);
        1: program_limits(0, 8191, -1000, 2000, -1000, 2000, 1);     // voltage never breaches
        2: program_limits(3000, 3600, 100, 300, 150, 250, WINDOW_MAX);
        3: program_limits(8191, 0, 2000, -1000, 2000, -1000, 0);     // always breaches
        4: program_limits(2500, 4200, -200, 600, 0, 450, 10);
        7: program_limits($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                          $urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                          $urandom_range(8191));                     // raw words, upper bits too
        default: program_limits(rand_between(2000, 3400), rand_between(3500, 4500),
                                rand_between(-1000, 0), rand_between(300, 2000),
                                rand_between(-500, 200), rand_between(200, 700),
                                rand_between(1, 12));
      endcase

      // none, sender idle, receiver stall, both
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase

      budget = n_pushed + PHASE_ITEMS;
      while (n_pushed < budget) begin
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(6, 1))
            queue_item(2'($urandom_range(3)), 4'($urandom_range(15)), VOLT_W'($urandom),
                       TEMP_W'($urandom));
        else
          queue_session();
      end

      // Sender keeps offering while results back up, so the input stalls.
      if (phase == HOLD_PHASE) hold_toggle = ~hold_toggle;

      drain_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/bps_pkg.sv
sv/bps_channels.sv
sv/battery_pack_supervisor_fsm.sv
sim/battery_pack_supervisor_fsm_test.sv
